// ----- rtl/core/i2cms_pkg.sv -----
`default_nettype none

package i2cms_pkg;

	// Item modes.
	localparam logic [2:0] MODE_LOAD  = 3'd0;
	localparam logic [2:0] MODE_WRITE = 3'd1;
	localparam logic [2:0] MODE_READ  = 3'd2;
	localparam logic [2:0] MODE_EVENT = 3'd3;
	localparam logic [2:0] MODE_ERROR = 3'd4;
	localparam logic [2:0] MODE_TICK  = 3'd5;

	// Bit positions in status_flags for event items.
	localparam int EV_SB   = 0;
	localparam int EV_ADDR = 1;
	localparam int EV_TXE  = 2;
	localparam int EV_RXNE = 4;

	// Bit positions in status_flags for error items.
	localparam int ER_AF = 0;

	// Configuration register indexes.
	localparam logic [1:0] REG_MAX_ERRORS = 2'd0;
	localparam logic [1:0] REG_TIMEOUT    = 2'd1;

	localparam logic [3:0]  MAX_ERRORS_RST = 4'd5;
	localparam logic [15:0] TIMEOUT_RST    = 16'd100;

	localparam int IDX_W = 5;
	localparam int LEN_W = 6;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_TX      = 2'd1,
		PH_RX      = 2'd2,
		PH_TIMEOUT = 2'd3
	} phase_t;

	typedef struct packed {
		logic [2:0]       mode;
		logic [IDX_W-1:0] buf_index;
		logic [7:0]       data_byte;
		logic [7:0]       slave_addr;
		logic [LEN_W-1:0] byte_count;
		logic             send_zero;
		logic [4:0]       status_flags;
	} item_t;

	typedef struct packed {
		logic             dr_write;
		logic [7:0]       dr_byte;
		logic             start_req;
		logic             stop_req;
		logic             ack_enable;
		logic             rx_valid;
		logic [7:0]       rx_byte;
		logic [IDX_W-1:0] rx_position;
		logic [1:0]       phase;
		logic [3:0]       error_count;
	} result_t;

	typedef struct packed {
		phase_t           phase;
		logic [7:0]       target;
		logic [LEN_W-1:0] tx_len;
		logic [LEN_W-1:0] rx_len;
		logic [LEN_W-1:0] bcnt;
		logic [3:0]       errs;
		logic             ack;
		logic [15:0]      ticks;
	} seq_state_t;

	// One write into the transmit store.
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [7:0]       data;
	} store_wr_t;

endpackage

`default_nettype wire

// ----- rtl/core/i2cms_if.sv -----
`default_nettype none

interface i2cms_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [4:0] buf_index;
	logic [7:0] data_byte;
	logic [7:0] slave_addr;
	logic [5:0] byte_count;
	logic       send_zero;
	logic [4:0] status_flags;

	modport source (output valid, mode, buf_index, data_byte, slave_addr, byte_count,
		send_zero, status_flags, input ready);
	modport sink (input valid, mode, buf_index, data_byte, slave_addr, byte_count,
		send_zero, status_flags, output ready);
endinterface

interface i2cms_rsp_if;
	logic       valid;
	logic       ready;
	logic       dr_write;
	logic [7:0] dr_byte;
	logic       start_req;
	logic       stop_req;
	logic       ack_enable;
	logic       rx_valid;
	logic [7:0] rx_byte;
	logic [4:0] rx_position;
	logic [1:0] phase;
	logic [3:0] error_count;

	modport source (output valid, dr_write, dr_byte, start_req, stop_req, ack_enable,
		rx_valid, rx_byte, rx_position, phase, error_count, input ready);
	modport sink (input valid, dr_write, dr_byte, start_req, stop_req, ack_enable,
		rx_valid, rx_byte, rx_position, phase, error_count, output ready);
endinterface

interface i2cms_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  reg_index;
	logic [15:0] wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/i2c_master_transaction_sequencer.sv -----
// An accepted item waits in stage 1 and its result in the stage 2 register.
// Throughput: one item per cycle while results are taken; stage 2 decouples the sides.
// The transmit store is a RAM with registered read, prefetched at the next byte index.
// Reset (arst_n low, asynchronous) idles the sequencer and restores max_errors 5,
// timeout_ticks 100; transmit store contents stay undefined until loaded.
`default_nettype none

module i2c_master_transaction_sequencer
	import i2cms_pkg::*;
#(
	parameter int BUF_DEPTH = 32
) (
	input wire logic   clk,
	input wire logic   arst_n,
	i2cms_cmd_if.sink  cmd,
	i2cms_rsp_if.source rsp,
	i2cms_cfg_if.sink  cfg
);

	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

	// Stage 1 holds the accepted item, stage 2 the finished result. The
	// sequencer state moves only when the stage 1 item passes into stage 2.
	logic       valid_s1;
	item_t      item_s1;
	logic       valid_s2;
	result_t    res_s2;
	logic       advance;
	logic       fire;

	seq_state_t state_q;
	seq_state_t step_nxt;
	seq_state_t state_d;
	result_t    step_res;
	store_wr_t  step_wr;

	logic [3:0]  max_errors_q;
	logic [15:0] timeout_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;
	logic          fwd_hit_q;
	logic [7:0]    fwd_data_q;
	logic [7:0]    store_byte;

	assign advance   = !valid_s2 || rsp.ready;
	assign fire      = valid_s1 && advance;
	assign cmd.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1.mode         <= cmd.mode;
			item_s1.buf_index    <= cmd.buf_index;
			item_s1.data_byte    <= cmd.data_byte;
			item_s1.slave_addr   <= cmd.slave_addr;
			item_s1.byte_count   <= cmd.byte_count;
			item_s1.send_zero    <= cmd.send_zero;
			item_s1.status_flags <= cmd.status_flags;
		end
	end

	// The user writes configuration only with no transaction in flight; not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_errors_q <= MAX_ERRORS_RST;
			timeout_q    <= TIMEOUT_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.reg_index)
				REG_MAX_ERRORS: max_errors_q <= cfg.wdata[3:0];
				REG_TIMEOUT:    timeout_q    <= cfg.wdata;
				default: begin
				end
			endcase
		end
	end

	i2cms_step #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_step (
		.cur          (state_q),
		.item         (item_s1),
		.max_errors   (max_errors_q),
		.timeout_ticks(timeout_q),
		.store_byte   (store_byte),
		.nxt          (step_nxt),
		.res          (step_res),
		.wr           (step_wr)
	);

	assign state_d = fire ? step_nxt : state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, default: '0};
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= step_res;
		end
	end

	// The store is read at the byte index the next item will see. A write in
	// the same cycle to that entry is forwarded around the RAM.
	assign ram_we    = fire && step_wr.en;
	assign ram_waddr = AW'(step_wr.addr);
	assign ram_raddr = AW'(state_d.bcnt);

	i2cms_ram #(
		.WIDTH(8),
		.DEPTH(BUF_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(step_wr.data),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else begin
			fwd_hit_q <= ram_we && (ram_waddr == ram_raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= step_wr.data;
	end

	assign store_byte = fwd_hit_q ? fwd_data_q : ram_rdata;

	assign rsp.valid       = valid_s2;
	assign rsp.dr_write    = res_s2.dr_write;
	assign rsp.dr_byte     = res_s2.dr_byte;
	assign rsp.start_req   = res_s2.start_req;
	assign rsp.stop_req    = res_s2.stop_req;
	assign rsp.ack_enable  = res_s2.ack_enable;
	assign rsp.rx_valid    = res_s2.rx_valid;
	assign rsp.rx_byte     = res_s2.rx_byte;
	assign rsp.rx_position = res_s2.rx_position;
	assign rsp.phase       = res_s2.phase;
	assign rsp.error_count = res_s2.error_count;

endmodule

`default_nettype wire

// ----- rtl/core/i2cms_ram.sv -----
`default_nettype none

module i2cms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the contents before a write in the same cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/i2cms_step.sv -----
`default_nettype none

module i2cms_step
	import i2cms_pkg::*;
#(
	parameter int BUF_DEPTH = 32
) (
	input  wire seq_state_t  cur,
	input  wire item_t       item,
	input  wire logic [3:0]  max_errors,
	input  wire logic [15:0] timeout_ticks,
	input  wire logic [7:0]  store_byte,
	output seq_state_t       nxt,
	output result_t          res,
	output store_wr_t        wr
);

	localparam int LEN_CAP = (BUF_DEPTH < 32) ? BUF_DEPTH : 32;
	localparam logic [LEN_W-1:0] CAP = LEN_W'(LEN_CAP);

	function automatic seq_state_t go_stop(seq_state_t s, phase_t p);
		seq_state_t t;
		t        = s;
		t.phase  = p;
		t.tx_len = '0;
		t.rx_len = '0;
		t.bcnt   = '0;
		return t;
	endfunction

	function automatic logic [3:0] bump(logic [3:0] e);
		return (e == 4'hF) ? e : e + 4'd1;
	endfunction

	logic             active;
	logic             fatal;
	logic [LEN_W-1:0] cap_cnt;

	assign active  = (cur.phase == PH_TX) || (cur.phase == PH_RX);
	assign fatal   = |item.status_flags[4:1];
	assign cap_cnt = (item.byte_count > CAP) ? CAP : item.byte_count;

	always_comb begin
		nxt = cur;
		res = '0;
		wr  = '0;

		unique case (item.mode)
			MODE_LOAD: begin
				if (32'(item.buf_index) < BUF_DEPTH) begin
					wr.en   = 1'b1;
					wr.addr = item.buf_index;
					wr.data = item.data_byte;
				end
			end
			MODE_WRITE, MODE_READ: begin
				nxt.target = item.slave_addr;
				if (item.mode == MODE_WRITE) begin
					if (item.send_zero) begin
						wr.en      = 1'b1;
						wr.addr    = '0;
						wr.data    = 8'h00;
						nxt.tx_len = LEN_W'(1);
					end else begin
						nxt.tx_len = cap_cnt;
					end
					nxt.rx_len = '0;
					nxt.phase  = PH_TX;
				end else begin
					nxt.rx_len = cap_cnt;
					nxt.tx_len = '0;
					nxt.phase  = PH_RX;
				end
				nxt.bcnt      = '0;
				nxt.errs      = '0;
				nxt.ticks     = '0;
				res.start_req = 1'b1;
			end
			MODE_EVENT: begin
				if (active) begin
					if (item.status_flags[EV_SB]) begin
						res.dr_write = 1'b1;
						res.dr_byte  = nxt.target;
					end
					if (item.status_flags[EV_ADDR] && nxt.phase == PH_RX) begin
						if (nxt.rx_len <= LEN_W'(1)) begin
							nxt.ack      = 1'b0;
							res.stop_req = 1'b1;
							if (nxt.rx_len == '0) begin
								nxt = go_stop(nxt, PH_IDLE);
							end
						end else begin
							nxt.ack = 1'b1;
						end
					end
					if (nxt.phase == PH_TX) begin
						if (item.status_flags[EV_TXE] && nxt.bcnt < nxt.tx_len) begin
							res.dr_write = 1'b1;
							res.dr_byte  = store_byte;
							nxt.bcnt     = nxt.bcnt + LEN_W'(1);
						end
						if (nxt.bcnt >= nxt.tx_len) begin
							res.stop_req = 1'b1;
							nxt = go_stop(nxt, PH_IDLE);
						end
					end
					if (item.status_flags[EV_RXNE] && nxt.phase == PH_RX
						&& nxt.bcnt < nxt.rx_len) begin
						res.rx_valid    = 1'b1;
						res.rx_byte     = item.data_byte;
						res.rx_position = nxt.bcnt[IDX_W-1:0];
						nxt.bcnt        = nxt.bcnt + LEN_W'(1);
						if (nxt.rx_len - nxt.bcnt == LEN_W'(1)) begin
							nxt.ack = 1'b0;
						end
						if (nxt.bcnt == nxt.rx_len) begin
							res.stop_req = 1'b1;
							nxt = go_stop(nxt, PH_IDLE);
						end
					end
				end
			end
			MODE_ERROR: begin
				if (active) begin
					if (item.status_flags[ER_AF]) begin
						// Address NACK restarts; data NACK steps back to resend.
						if (nxt.bcnt == '0) begin
							res.stop_req  = 1'b1;
							res.start_req = 1'b1;
						end else begin
							nxt.bcnt = nxt.bcnt - LEN_W'(1);
						end
						nxt.errs = bump(nxt.errs);
					end
					if (fatal) begin
						nxt.errs = bump(max_errors);
					end
					nxt.errs = bump(nxt.errs);
					if (fatal || nxt.errs > max_errors) begin
						res.start_req = 1'b0;
						nxt = go_stop(nxt, PH_IDLE);
					end
				end
			end
			MODE_TICK: begin
				if (active) begin
					if (nxt.ticks != 16'hFFFF) begin
						nxt.ticks = nxt.ticks + 16'd1;
					end
					if (nxt.ticks > timeout_ticks) begin
						nxt = go_stop(nxt, PH_TIMEOUT);
					end
				end
			end
			default: begin
			end
		endcase

		res.ack_enable  = nxt.ack;
		res.phase       = nxt.phase;
		res.error_count = nxt.errs;
	end

endmodule

`default_nettype wire

// ----- rtl/core/i2cms_checker.sv -----
`default_nettype none

module i2cms_checker
	import i2cms_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic       rsp_dr_write,
	input wire logic [7:0] rsp_dr_byte,
	input wire logic       rsp_start_req,
	input wire logic       rsp_rx_valid,
	input wire logic [1:0] rsp_phase,
	input wire logic [3:0] rsp_error_count
);

	// No result is offered in the cycle after reset has been held.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !rsp_valid)
		else $error("result valid after reset");

	// A stalled result stays valid and holds its data byte, phase and error count.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid
			&& $stable({rsp_dr_byte, rsp_phase, rsp_error_count}))
		else $error("stalled result changed");

	// A start request leaves a transaction running.
	a_start_active: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_start_req |-> rsp_phase == PH_TX || rsp_phase == PH_RX)
		else $error("start requested while not active");

	// A received byte comes only from a read, which then runs on or ends idle.
	a_rx_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_rx_valid |-> rsp_phase == PH_RX || rsp_phase == PH_IDLE)
		else $error("received byte outside a read");

	// With no byte to drive the data field reads zero.
	a_dr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_dr_write |-> rsp_dr_byte == 8'h00)
		else $error("data byte set without a write");

endmodule

bind i2c_master_transaction_sequencer i2cms_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_dr_write   (rsp.dr_write),
	.rsp_dr_byte    (rsp.dr_byte),
	.rsp_start_req  (rsp.start_req),
	.rsp_rx_valid   (rsp.rx_valid),
	.rsp_phase      (rsp.phase),
	.rsp_error_count(rsp.error_count)
);

`default_nettype wire

// ----- tb/tb.sv -----
module tb
	import i2cms_pkg::*;
();

	// Generous ceiling on the run, far above what the slowest legal run needs
	// (receiver ready least often, sender gaps at their longest).
	localparam int CYCLE_LIMIT = 400000;
	localparam int STORE_DEPTH = 32;
	localparam int PHASE_ITEMS = 160;
	localparam logic [5:0] LEN_CAP = 6'd32;

	// Event flag masks. BTF has no name in the package, so it gets one here.
	localparam int EV_BTF = 3;
	localparam logic [4:0] F_SB   = 5'(1 << EV_SB);
	localparam logic [4:0] F_ADDR = 5'(1 << EV_ADDR);
	localparam logic [4:0] F_TXE  = 5'(1 << EV_TXE);
	localparam logic [4:0] F_BTF  = 5'(1 << EV_BTF);
	localparam logic [4:0] F_RXNE = 5'(1 << EV_RXNE);
	localparam logic [4:0] F_ALL  = F_SB | F_ADDR | F_TXE | F_BTF | F_RXNE;

	// Error flag masks. Everything but AF is fatal.
	localparam logic [4:0] E_AF    = 5'(1 << ER_AF);
	localparam logic [4:0] E_ARLO  = 5'b00010;
	localparam logic [4:0] E_TMO   = 5'b00100;
	localparam logic [4:0] E_OVR   = 5'b01000;
	localparam logic [4:0] E_BERR  = 5'b10000;
	localparam logic [4:0] E_FATAL = E_ARLO | E_TMO | E_OVR | E_BERR;

	// Mode code with no meaning; the block must leave its state alone.
	localparam logic [2:0] MODE_RSVD = 3'd6;

	typedef struct packed {
		item_t   it;
		logic    fixed;
		result_t res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	i2cms_cmd_if cmd_ch ();
	i2cms_rsp_if rsp_ch ();
	i2cms_cfg_if cfg_ch ();

	i2c_master_transaction_sequencer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Our own copy of the sequencer state and its two registers.
	logic [7:0]  sq_store [STORE_DEPTH];
	phase_t      sq_phase;
	logic [7:0]  sq_target;
	logic [5:0]  sq_tx_len;
	logic [5:0]  sq_rx_len;
	logic [5:0]  sq_bcnt;
	logic [3:0]  sq_errs;
	logic        sq_ack;
	logic [15:0] sq_ticks;
	logic [3:0]  cfg_max_err;
	logic [15:0] cfg_timeout;

	// Results still owed by the block, oldest first.
	result_t pending_rsp [$];

	int mismatch_cnt = 0;
	int cycle_cnt = 0;
	int items_sent = 0;
	int burst_left = 0;
	int rcv_tick = 0;
	int rcv_style = 0;

	function automatic logic [5:0] cap_len(input logic [5:0] n);
		return (n > LEN_CAP) ? LEN_CAP : n;
	endfunction

	function void end_transfer(input phase_t next_phase);
		sq_phase = next_phase;
		sq_tx_len = '0;
		sq_rx_len = '0;
		sq_bcnt = '0;
	endfunction

	function void err_bump();
		if (sq_errs != 4'd15) sq_errs = sq_errs + 4'd1;
	endfunction

	// Applies one accepted item to the state copy and returns what the block
	// has to answer with.
	function automatic result_t advance_sequencer(input item_t it);
		result_t r;
		logic    active;
		logic    fatal;
		r = '0;
		active = (sq_phase == PH_TX) || (sq_phase == PH_RX);
		case (it.mode)
			MODE_LOAD: begin
				sq_store[it.buf_index] = it.data_byte;
			end
			MODE_WRITE, MODE_READ: begin
				// A begin replaces whatever transfer was running; ACK is untouched.
				sq_target = it.slave_addr;
				if (it.mode == MODE_WRITE) begin
					if (it.send_zero) begin
						sq_store[0] = 8'h00;
						sq_tx_len = 6'd1;
					end else begin
						sq_tx_len = cap_len(it.byte_count);
					end
					sq_rx_len = '0;
					sq_phase = PH_TX;
				end else begin
					sq_rx_len = cap_len(it.byte_count);
					sq_tx_len = '0;
					sq_phase = PH_RX;
				end
				sq_bcnt = '0;
				sq_errs = '0;
				sq_ticks = '0;
				r.start_req = 1'b1;
			end
			MODE_EVENT: if (active) begin
				// Flags are taken in the order SB, ADDR, TXE, end of write, RXNE.
				if (it.status_flags[EV_SB]) begin
					r.dr_write = 1'b1;
					r.dr_byte = sq_target;
				end
				if (it.status_flags[EV_ADDR] && sq_phase == PH_RX) begin
					if (sq_rx_len <= 6'd1) begin
						sq_ack = 1'b0;
						r.stop_req = 1'b1;
						if (sq_rx_len == 6'd0) end_transfer(PH_IDLE);
					end else begin
						sq_ack = 1'b1;
					end
				end
				if (sq_phase == PH_TX) begin
					if (it.status_flags[EV_TXE] && sq_bcnt < sq_tx_len) begin
						r.dr_write = 1'b1;
						r.dr_byte = sq_store[sq_bcnt[4:0]];
						sq_bcnt = sq_bcnt + 6'd1;
					end
					if (sq_bcnt >= sq_tx_len) begin
						r.stop_req = 1'b1;
						end_transfer(PH_IDLE);
					end
				end
				if (it.status_flags[EV_RXNE] && sq_phase == PH_RX && sq_bcnt < sq_rx_len) begin
					r.rx_valid = 1'b1;
					r.rx_byte = it.data_byte;
					r.rx_position = sq_bcnt[4:0];
					sq_bcnt = sq_bcnt + 6'd1;
					if (sq_rx_len - sq_bcnt == 6'd1) sq_ack = 1'b0;
					if (sq_bcnt == sq_rx_len) begin
						r.stop_req = 1'b1;
						end_transfer(PH_IDLE);
					end
				end
			end
			MODE_ERROR: if (active) begin
				fatal = |(it.status_flags & E_FATAL);
				if (it.status_flags[ER_AF]) begin
					// NACK on the address restarts; NACK on data resends the byte.
					if (sq_bcnt == 6'd0) begin
						r.stop_req = 1'b1;
						r.start_req = 1'b1;
					end else begin
						sq_bcnt = sq_bcnt - 6'd1;
					end
					err_bump();
				end
				if (fatal) sq_errs = (cfg_max_err == 4'd15) ? 4'd15 : cfg_max_err + 4'd1;
				err_bump();
				if (fatal || sq_errs > cfg_max_err) begin
					r.start_req = 1'b0;
					end_transfer(PH_IDLE);
				end
			end
			MODE_TICK: if (active) begin
				if (sq_ticks != 16'hFFFF) sq_ticks = sq_ticks + 16'd1;
				if (sq_ticks > cfg_timeout) end_transfer(PH_TIMEOUT);
			end
			default: ;
		endcase
		r.ack_enable = sq_ack;
		r.phase = sq_phase;
		r.error_count = sq_errs;
		return r;
	endfunction

	function automatic item_t mk_item(input logic [2:0] m, input logic [4:0] idx,
		input logic [7:0] d, input logic [7:0] a, input logic [5:0] c, input logic z,
		input logic [4:0] f);
		item_t it;
		it.mode = m;
		it.buf_index = idx;
		it.data_byte = d;
		it.slave_addr = a;
		it.byte_count = c;
		it.send_zero = z;
		it.status_flags = f;
		return it;
	endfunction

	// Random content in every field; callers override what the mode needs.
	function automatic item_t rand_item(input logic [2:0] m);
		return mk_item(m, 5'($urandom), 8'($urandom), 8'($urandom), 6'($urandom),
			1'($urandom), 5'($urandom));
	endfunction

	function automatic result_t mk_res(input logic drw, input logic [7:0] drb,
		input logic st, input logic sp, input logic ack, input phase_t ph,
		input logic [3:0] ec);
		result_t r;
		r = '0;
		r.dr_write = drw;
		r.dr_byte = drb;
		r.start_req = st;
		r.stop_req = sp;
		r.ack_enable = ack;
		r.phase = ph;
		r.error_count = ec;
		return r;
	endfunction

	// Mostly short transfers, some up to the full store, a few past the cap.
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return $urandom_range(0, 5);
		if (r < 93) return $urandom_range(6, 32);
		return $urandom_range(33, 63);
	endfunction

	task compare_field(input string name, input logic [7:0] want, input logic [7:0] seen);
		if (seen !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
			mismatch_cnt++;
		end
	endtask

	// Sends one item in bursts of random length with random gaps in between.
	// Valid stays high from one item to the next inside a burst. The answer is
	// worked out at the edge that accepts the item; a row with a typed-in answer
	// still runs through the state copy so that later rows stay in step.
	task send_item(input item_t it, input logic fixed, input result_t res);
		result_t want;
		if (burst_left == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
				: $urandom_range(1, 12);
		end
		burst_left--;
		cmd_ch.valid <= 1'b1;
		cmd_ch.mode <= it.mode;
		cmd_ch.buf_index <= it.buf_index;
		cmd_ch.data_byte <= it.data_byte;
		cmd_ch.slave_addr <= it.slave_addr;
		cmd_ch.byte_count <= it.byte_count;
		cmd_ch.send_zero <= it.send_zero;
		cmd_ch.status_flags <= it.status_flags;
		do @(posedge clk); while (!cmd_ch.ready);
		want = advance_sequencer(it);
		if (fixed) want = res;
		pending_rsp.push_back(want);
		items_sent++;
	endtask

	// One step of a transfer, now and then preceded by something that gets in
	// the way: a tick, a data or address NACK, an error with random flags, a
	// store load in the middle of a transfer, or a stray event.
	task send_step(input item_t it);
		item_t extra;
		int    pick;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			if (pick < 8) begin
				extra = rand_item(MODE_TICK);
			end else if (pick < 15) begin
				extra = rand_item(MODE_ERROR);
				if (pick < 14) extra.status_flags = E_AF;
			end else if (pick < 17) begin
				extra = rand_item(MODE_LOAD);
			end else begin
				extra = rand_item(MODE_EVENT);
			end
			send_item(extra, 1'b0, '0);
		end
		send_item(it, 1'b0, '0);
	endtask

	// Occasionally a long run of ticks, which can push past a short timeout.
	task tick_run();
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(1, 130)) send_item(rand_item(MODE_TICK), 1'b0, '0);
		end
	endtask

	task send_write_transfer();
		item_t it;
		int    len;
		repeat ($urandom_range(0, 3)) send_item(rand_item(MODE_LOAD), 1'b0, '0);
		it = rand_item(MODE_WRITE);
		len = pick_len();
		it.byte_count = 6'(len);
		it.send_zero = ($urandom_range(0, 9) == 0);
		send_item(it, 1'b0, '0);
		if (it.send_zero) len = 1;
		else if (len > STORE_DEPTH) len = STORE_DEPTH;
		it = rand_item(MODE_EVENT);
		it.status_flags = ($urandom_range(0, 3) == 0) ? (F_SB | F_ADDR) : F_SB;
		send_step(it);
		if (it.status_flags == F_SB) begin
			it = rand_item(MODE_EVENT);
			it.status_flags = F_ADDR;
			send_step(it);
		end
		// One TXE per byte plus one spare, in case a NACK stepped the index back.
		for (int k = 0; k <= len; k++) begin
			it = rand_item(MODE_EVENT);
			it.status_flags = F_TXE | (($urandom_range(0, 2) == 0) ? F_BTF : 5'b00000);
			if ($urandom_range(0, 19) == 0) it.status_flags = 5'($urandom);
			send_step(it);
		end
		tick_run();
	endtask

	task send_read_transfer();
		item_t it;
		int    len;
		it = rand_item(MODE_READ);
		len = pick_len();
		it.byte_count = 6'(len);
		send_item(it, 1'b0, '0);
		if (len > STORE_DEPTH) len = STORE_DEPTH;
		it = rand_item(MODE_EVENT);
		it.status_flags = F_SB;
		send_step(it);
		it = rand_item(MODE_EVENT);
		it.status_flags = F_ADDR;
		send_step(it);
		// Sometimes one RXNE more than the read asked for.
		for (int k = 0; k < len + $urandom_range(0, 1); k++) begin
			it = rand_item(MODE_EVENT);
			it.status_flags = F_RXNE | (($urandom_range(0, 2) == 0) ? F_BTF : 5'b00000);
			if ($urandom_range(0, 19) == 0) it.status_flags = 5'($urandom);
			send_step(it);
		end
		tick_run();
	endtask

	// Stops sending, waits until every owed result has come back, and then lets
	// the result register empty.
	task settle();
		cmd_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wdata <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_MAX_ERRORS) cfg_max_err = val[3:0];
		else if (idx == REG_TIMEOUT) cfg_timeout = val;
	endtask

	// Result side. Every accepted result item is matched against the oldest
	// owed one. Ready follows a pattern picked anew at random during the run:
	// always ready, ready three quarters or a fifth of the time, or coin flips.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				$error("result item arrived with no expectation waiting");
				mismatch_cnt++;
			end else begin
				want = pending_rsp.pop_front();
				compare_field("dr_write", 8'(want.dr_write), 8'(rsp_ch.dr_write));
				compare_field("dr_byte", want.dr_byte, rsp_ch.dr_byte);
				compare_field("start_req", 8'(want.start_req), 8'(rsp_ch.start_req));
				compare_field("stop_req", 8'(want.stop_req), 8'(rsp_ch.stop_req));
				compare_field("ack_enable", 8'(want.ack_enable), 8'(rsp_ch.ack_enable));
				compare_field("rx_valid", 8'(want.rx_valid), 8'(rsp_ch.rx_valid));
				compare_field("rx_byte", want.rx_byte, rsp_ch.rx_byte);
				compare_field("rx_position", 8'(want.rx_position), 8'(rsp_ch.rx_position));
				compare_field("phase", 8'(want.phase), 8'(rsp_ch.phase));
				compare_field("error_count", 8'(want.error_count), 8'(rsp_ch.error_count));
			end
		end
		rcv_tick++;
		if (rcv_tick % 64 == 0) rcv_style = $urandom_range(0, 3);
		case (rcv_style)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= (rcv_tick % 4 != 3);
			2: rsp_ch.ready <= 1'($urandom_range(0, 1));
			default: rsp_ch.ready <= (rcv_tick % 5 == 0);
		endcase
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		dir_row_t   dir_rows [$];
		item_t      it;
		int         target;
		int         kind;
		logic [3:0] plan_err [5];
		logic [15:0] plan_tmo [5];

		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = MODE_LOAD;
		cmd_ch.buf_index = '0;
		cmd_ch.data_byte = '0;
		cmd_ch.slave_addr = '0;
		cmd_ch.byte_count = '0;
		cmd_ch.send_zero = 1'b0;
		cmd_ch.status_flags = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.reg_index = REG_MAX_ERRORS;
		cfg_ch.wdata = '0;

		sq_phase = PH_IDLE;
		sq_target = '0;
		sq_tx_len = '0;
		sq_rx_len = '0;
		sq_bcnt = '0;
		sq_errs = '0;
		sq_ack = 1'b0;
		sq_ticks = '0;
		cfg_max_err = MAX_ERRORS_RST;
		cfg_timeout = TIMEOUT_RST;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The store is undefined after reset, so every entry is loaded before
		// any write transfer can send from it.
		for (int i = 0; i < STORE_DEPTH; i++) begin
			it = rand_item(MODE_LOAD);
			it.buf_index = 5'(i);
			send_item(it, 1'b0, '0);
		end

		// Directed rows. The first ones run while idle, where nothing but loads
		// may have an effect; answers that are plain to see are typed in.
		dir_rows.push_back(dir_row_t'{mk_item(MODE_EVENT, 0, 0, 0, 0, 0, F_ALL),
			1'b1, mk_res(0, 0, 0, 0, 0, PH_IDLE, 0)});
		dir_rows.push_back(dir_row_t'{mk_item(MODE_ERROR, 0, 0, 0, 0, 0, E_AF | E_FATAL),
			1'b1, mk_res(0, 0, 0, 0, 0, PH_IDLE, 0)});
		dir_rows.push_back(dir_row_t'{mk_item(MODE_TICK, 0, 0, 0, 0, 0, 0),
			1'b1, mk_res(0, 0, 0, 0, 0, PH_IDLE, 0)});
		dir_rows.push_back(dir_row_t'{mk_item(MODE_RSVD, 5'h1F, 8'hFF, 8'hFF, 6'h3F, 1, F_ALL),
			1'b1, mk_res(0, 0, 0, 0, 0, PH_IDLE, 0)});
		dir_rows.push_back(dir_row_t'{mk_item(MODE_LOAD, 5'h1F, 8'hFF, 0, 0, 0, 0),
			1'b1, mk_res(0, 0, 0, 0, 0, PH_IDLE, 0)});
		// Write with a length far past the cap, then the address byte on SB.
		dir_rows.push_back(dir_row_t'{mk_item(MODE_WRITE, 0, 0, 8'hFF, 6'h3F, 0, 0),
			1'b1, mk_res(0, 0, 1, 0, 0, PH_TX, 0)});
		dir_rows.push_back(dir_row_t'{mk_item(MODE_EVENT, 0, 0, 0, 0, 0, F_SB),
			1'b1, mk_res(1, 8'hFF, 0, 0, 0, PH_TX, 0)});
		// ADDR means nothing to a write; TXE sends entry zero. A data NACK
		// steps back, and arbitration loss aborts.
		dir_rows.push_back(dir_row_t'{mk_item(MODE_EVENT, 0, 0, 0, 0, 0, F_ADDR | F_TXE),
			1'b0, '0});
		dir_rows.push_back(dir_row_t'{mk_item(MODE_ERROR, 0, 0, 0, 0, 0, E_AF), 1'b0, '0});
		dir_rows.push_back(dir_row_t'{mk_item(MODE_ERROR, 0, 0, 0, 0, 0, E_ARLO), 1'b0, '0});
		// The single zero byte write, and a zero-length write that ends on BTF.
		dir_rows.push_back(dir_row_t'{mk_item(MODE_WRITE, 0, 0, 8'hA0, 0, 1, 0), 1'b0, '0});
		dir_rows.push_back(dir_row_t'{mk_item(MODE_EVENT, 0, 0, 0, 0, 0, F_TXE | F_BTF),
			1'b0, '0});
		dir_rows.push_back(dir_row_t'{mk_item(MODE_WRITE, 0, 0, 8'h00, 0, 0, 0), 1'b0, '0});
		dir_rows.push_back(dir_row_t'{mk_item(MODE_EVENT, 0, 0, 0, 0, 0, F_BTF), 1'b0, '0});
		// One-byte read keeps ACK off; a zero-byte read stops on ADDR.
		dir_rows.push_back(dir_row_t'{mk_item(MODE_READ, 0, 0, 8'h01, 1, 0, 0), 1'b0, '0});
		dir_rows.push_back(dir_row_t'{mk_item(MODE_EVENT, 0, 0, 0, 0, 0, F_SB | F_ADDR),
			1'b0, '0});
		dir_rows.push_back(dir_row_t'{mk_item(MODE_EVENT, 0, 8'hFF, 0, 0, 0, F_RXNE),
			1'b0, '0});
		dir_rows.push_back(dir_row_t'{mk_item(MODE_READ, 0, 0, 8'h7F, 0, 0, 0), 1'b0, '0});
		dir_rows.push_back(dir_row_t'{mk_item(MODE_EVENT, 0, 0, 0, 0, 0, F_ADDR), 1'b0, '0});
		// Three-byte read: ACK on, one byte, a NACK, then a write that
		// replaces the read, an address NACK restart and a fatal abort.
		dir_rows.push_back(dir_row_t'{mk_item(MODE_READ, 0, 0, 8'h55, 3, 0, 0), 1'b0, '0});
		dir_rows.push_back(dir_row_t'{mk_item(MODE_EVENT, 0, 0, 0, 0, 0, F_ADDR), 1'b0, '0});
		dir_rows.push_back(dir_row_t'{mk_item(MODE_EVENT, 0, 8'h00, 0, 0, 0, F_RXNE),
			1'b0, '0});
		dir_rows.push_back(dir_row_t'{mk_item(MODE_ERROR, 0, 0, 0, 0, 0, E_AF), 1'b0, '0});
		dir_rows.push_back(dir_row_t'{mk_item(MODE_WRITE, 0, 0, 8'h3C, 2, 0, 0), 1'b0, '0});
		dir_rows.push_back(dir_row_t'{mk_item(MODE_ERROR, 0, 0, 0, 0, 0, E_AF), 1'b0, '0});
		dir_rows.push_back(dir_row_t'{mk_item(MODE_ERROR, 0, 0, 0, 0, 0,
			E_TMO | E_OVR | E_BERR), 1'b0, '0});

		foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].res);

		// Random part in six phases. The first runs on the reset values of the
		// registers; the others write both registers while no item is in flight,
		// covering values near both ends of each range on the way.
		plan_err = '{4'd0, 4'd14, 4'd3, 4'($urandom_range(0, 14)), MAX_ERRORS_RST};
		plan_tmo = '{16'd1, 16'hFFFF, 16'd12, 16'($urandom_range(1, 300)), TIMEOUT_RST};
		for (int p = 0; p < 6; p++) begin
			if (p > 0) begin
				settle();
				write_reg(REG_MAX_ERRORS, 16'(plan_err[p-1]));
				write_reg(REG_TIMEOUT, plan_tmo[p-1]);
			end
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				// Mostly well-formed transfers with random content, some noise.
				kind = $urandom_range(0, 99);
				if (kind < 42) begin
					send_write_transfer();
				end else if (kind < 84) begin
					send_read_transfer();
				end else begin
					repeat ($urandom_range(1, 4))
						send_item(rand_item(3'($urandom_range(0, 7))), 1'b0, '0);
				end
			end
		end

		settle();
		if (mismatch_cnt == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- i2c_master_transaction_sequencer.f -----
rtl/core/i2cms_pkg.sv
rtl/core/i2cms_if.sv
rtl/core/i2cms_ram.sv
rtl/core/i2cms_step.sv
rtl/core/i2c_master_transaction_sequencer.sv
rtl/core/i2cms_checker.sv
tb/tb.sv
